[design/lcl_pkg.sv]
// ----------------------------------------------------------------------------
// lcl_pkg: shared types and constants of the line/column locator
// Request codes, the queued item format, queue sizing and the byte
// values that mark line terminators in UTF-8 text.
// ----------------------------------------------------------------------------
package lcl_pkg;

	// request codes on req_type
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// field widths fixed by the interface
	localparam int BYTE_W    = 8;
	localparam int PAYLOAD_W = 20;
	localparam int LINE_W    = 13;
	localparam int COL_W     = 21;

	// item queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// terminator bytes
	localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0a;
	localparam logic [BYTE_W-1:0] BYTE_CR   = 8'h0d;
	localparam logic [BYTE_W-1:0] UTF_LEAD  = 8'he2;
	localparam logic [BYTE_W-1:0] UTF_CONT  = 8'h80;
	localparam logic [BYTE_W-1:0] UTF_LSEP  = 8'ha8;
	localparam logic [BYTE_W-1:0] UTF_PSEP  = 8'ha9;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_LOAD,
		KIND_QUERY
	} kind_t;

	// one classified item: byte in the low bits for a load, offset for a query
	typedef struct packed {
		kind_t                kind;
		logic [PAYLOAD_W-1:0] payload;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

[design/lcl_front.sv]
// ----------------------------------------------------------------------------
// lcl_front: item intake
// Takes command items, sorts them into clear, load and query, and drops
// unused request codes before they reach the queue.
// ----------------------------------------------------------------------------
module lcl_front import lcl_pkg::*; (
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic [PAYLOAD_W-1:0] query_offset,
	output logic                 push,
	output item_t                push_item
);

	logic accept;

	assign accept = start && !busy;

	always_comb begin
		push_item.kind    = KIND_CLEAR;
		push_item.payload = '0;
		push              = 1'b0;
		case (req_type)
			REQ_CLEAR: begin
				push = accept;
			end
			REQ_LOAD: begin
				push_item.kind    = KIND_LOAD;
				push_item.payload = PAYLOAD_W'(text_byte);
				push              = accept;
			end
			REQ_QUERY: begin
				push_item.kind    = KIND_QUERY;
				push_item.payload = query_offset;
				push              = accept;
			end
			default: begin
				// unused code: accepted and dropped
				push = 1'b0;
			end
		endcase
	end

endmodule

[design/lcl_queue.sv]
// ----------------------------------------------------------------------------
// lcl_queue: item queue
// Short first-in first-out store that lets intake keep taking bytes while
// the back end runs a search.
// ----------------------------------------------------------------------------
module lcl_queue import lcl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  push_item,
	input  logic   pop,
	output item_t  head,
	output qstat_t stat
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("item queue count beyond depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("item queue count did not follow a push");

endmodule

[design/lcl_back.sv]
// ----------------------------------------------------------------------------
// lcl_back: line start table and search engine
// Applies clear and load items, keeping the line start table in a memory
// with one write and one read port, and answers queries by binary search.
// ----------------------------------------------------------------------------
module lcl_back import lcl_pkg::*; #(
	parameter int MAX_LINES   = 4096,
	parameter int OFFSET_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                head,
	input  qstat_t               stat,
	output logic                 pop,
	output logic                 done,
	output logic [LINE_W-1:0]    line_no,
	output logic [COL_W-1:0]     column_no,
	output logic [PAYLOAD_W-1:0] echo_offset,
	output logic                 table_full
);

	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int LW = $clog2(MAX_LINES + 1);
	localparam int EW = (OFFSET_BITS > COL_W) ? OFFSET_BITS : COL_W;
	localparam logic [PAYLOAD_W-1:0] QMASK = (OFFSET_BITS >= PAYLOAD_W) ?
		{PAYLOAD_W{1'b1}} : PAYLOAD_W'((64'd1 << OFFSET_BITS) - 64'd1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_STEP_RD  = 3'd1;
	localparam logic [2:0] ST_STEP_CMP = 3'd2;
	localparam logic [2:0] ST_FIN_RD   = 3'd3;
	localparam logic [2:0] ST_FIN_OUT  = 3'd4;

	// line start table; entry 0 is never written, zero is used in its place
	logic [OFFSET_BITS-1:0] table_mem [MAX_LINES];
	logic [OFFSET_BITS-1:0] rd_data_q;
	logic [AW-1:0]          rd_addr;
	logic                   we;
	logic [AW-1:0]          wr_addr;

	logic [2:0]             state_q;
	logic [LW-1:0]          line_count_q;
	logic [OFFSET_BITS-1:0] next_ofs_q;
	logic [OFFSET_BITS-1:0] last_start_q;
	logic [BYTE_W-1:0]      prev_q;
	logic [BYTE_W-1:0]      pprev_q;
	logic                   ovf_q;
	logic [LW-1:0]          first_q;
	logic [LW-1:0]          count_q;
	logic [LW-1:0]          mid_q;
	logic [PAYLOAD_W-1:0]   q_q;
	logic                   done_q;

	logic [LINE_W-1:0]      line_no_q;
	logic [COL_W-1:0]       column_no_q;
	logic [PAYLOAD_W-1:0]   echo_q;
	logic                   full_q;

	logic                   do_load;
	logic [BYTE_W-1:0]      byte_v;
	logic [OFFSET_BITS-1:0] after;
	logic                   is_lf;
	logic                   is_cr;
	logic                   crlf;
	logic                   add;
	logic                   has_room;
	logic                   mov;
	logic [LW-1:0]          lc_minus1;
	logic [LW-1:0]          half;
	logic [LW-1:0]          mid_c;
	logic [LW-1:0]          first_m1;
	logic                   q_below;
	logic [LW-1:0]          cnt_nx;
	logic [EW-1:0]          start_v;
	logic [EW-1:0]          col_v;

	assign pop     = (state_q == ST_IDLE) && !stat.empty;
	assign do_load = pop && (head.kind == KIND_LOAD);

	// terminator detection
	assign byte_v   = head.payload[BYTE_W-1:0];
	assign after    = next_ofs_q + OFFSET_BITS'(1);
	assign is_lf    = (byte_v == BYTE_LF);
	assign is_cr    = (byte_v == BYTE_CR);
	assign crlf     = is_lf && (prev_q == BYTE_CR);
	assign add      = !crlf && (is_lf || is_cr || ((pprev_q == UTF_LEAD) &&
		(prev_q == UTF_CONT) && ((byte_v == UTF_LSEP) || (byte_v == UTF_PSEP))));
	assign has_room = (line_count_q < LW'(MAX_LINES));
	assign mov      = crlf && (line_count_q > LW'(1)) && (last_start_q == next_ofs_q);
	assign lc_minus1 = line_count_q - LW'(1);
	assign we       = do_load && (mov || (add && has_room));
	assign wr_addr  = mov ? lc_minus1[AW-1:0] : line_count_q[AW-1:0];

	// search datapath
	assign half     = count_q >> 1;
	assign mid_c    = first_q + half;
	assign first_m1 = first_q - LW'(1);
	assign rd_addr  = (state_q == ST_FIN_RD) ? first_m1[AW-1:0] : mid_c[AW-1:0];
	assign q_below  = (EW'(q_q) < EW'(rd_data_q));
	assign cnt_nx   = q_below ? half : (count_q - half - LW'(1));
	assign start_v  = (first_q == LW'(1)) ? '0 : EW'(rd_data_q);
	assign col_v    = EW'(q_q) - start_v + EW'(1);

	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[wr_addr] <= after;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_count_q <= LW'(1);
			next_ofs_q   <= '0;
			last_start_q <= '0;
			prev_q       <= '0;
			pprev_q      <= '0;
			ovf_q        <= 1'b0;
			first_q      <= LW'(1);
			count_q      <= '0;
			mid_q        <= '0;
			q_q          <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.kind)
							KIND_CLEAR: begin
								line_count_q <= LW'(1);
								next_ofs_q   <= '0;
								last_start_q <= '0;
								prev_q       <= '0;
								pprev_q      <= '0;
								ovf_q        <= 1'b0;
							end
							KIND_LOAD: begin
								prev_q     <= byte_v;
								pprev_q    <= prev_q;
								next_ofs_q <= after;
								if (mov) begin
									last_start_q <= after;
								end else if (add) begin
									if (has_room) begin
										line_count_q <= line_count_q + LW'(1);
										last_start_q <= after;
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							KIND_QUERY: begin
								q_q     <= head.payload & QMASK;
								first_q <= LW'(1);
								count_q <= lc_minus1;
								state_q <= (lc_minus1 != '0) ? ST_STEP_RD : ST_FIN_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_STEP_RD: begin
					mid_q   <= mid_c;
					state_q <= ST_STEP_CMP;
				end
				ST_STEP_CMP: begin
					if (!q_below) begin
						first_q <= mid_q + LW'(1);
					end
					count_q <= cnt_nx;
					state_q <= (cnt_nx != '0) ? ST_STEP_RD : ST_FIN_RD;
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN_OUT;
				end
				ST_FIN_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN_OUT) begin
			line_no_q   <= LINE_W'(first_q);
			column_no_q <= col_v[COL_W-1:0];
			echo_q      <= q_q;
			full_q      <= ovf_q;
		end
	end

	assign done        = done_q;
	assign line_no     = line_no_q;
	assign column_no   = column_no_q;
	assign echo_offset = echo_q;
	assign table_full  = full_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_FIN_OUT))
		else $error("result strobe without a finished search");

	a_cmp_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP_CMP) |-> (count_q != '0))
		else $error("search compare with an empty range");

	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((first_q <= line_count_q) && (first_q != '0)))
		else $error("search position outside the line table");

endmodule

[design/line_column_locator.sv]
// ----------------------------------------------------------------------------
// line_column_locator: byte offset to line and column lookup
// Records line starts of a UTF-8 text loaded one byte per item and maps
// queried offsets to one-based line and column numbers.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload                                  dir
//  -------   ---------------  ---------------------------------------  ---
//  command   start / busy     req_type, text_byte, query_offset        in
//  result    done (strobe)    line_no, column_no, echo_offset,          out
//                             table_full
//
//  flow: a clear or load item is applied as it leaves the queue, so bytes
//    stream at one per cycle while no query is in the back end. a query
//    runs k rounds of the binary search, k being the number of halvings
//    (at most clog2 of the line count); with the registered read of the
//    table memory each round issues one read, then one compare.
//  the result strobe is registered in the final search state, ST_FIN_OUT.
//  reset: arst_n clears all control state; no clearing pass is needed as
//    entry 0 of the table is never written and its read data is unused
//    (zero stands in for it), and only written entries are used.
//  stalls: busy is high while the four-entry item queue is full; the
//    receiver cannot stall, results are shown for exactly one cycle.
//
module line_column_locator import lcl_pkg::*; #(
	parameter int MAX_LINES   = 4096,
	parameter int OFFSET_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic [PAYLOAD_W-1:0] query_offset,
	output logic                 done,
	output logic [LINE_W-1:0]    line_no,
	output logic [COL_W-1:0]     column_no,
	output logic [PAYLOAD_W-1:0] echo_offset,
	output logic                 table_full
);

	// front to queue
	logic   push;
	item_t  push_item;

	// queue to back
	item_t  head;
	qstat_t stat;
	logic   pop;

	// the only back pressure is a full queue
	assign busy = stat.full;

	// intake: classify, drop unused codes
	lcl_front u_front (
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.text_byte    (text_byte),
		.query_offset (query_offset),
		.push         (push),
		.push_item    (push_item)
	);

	// decoupling queue so byte intake continues during a search
	lcl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// table upkeep and binary search
	lcl_back #(
		.MAX_LINES   (MAX_LINES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.done        (done),
		.line_no     (line_no),
		.column_no   (column_no),
		.echo_offset (echo_offset),
		.table_full  (table_full)
	);

endmodule

[bench/line_column_locator_tb.sv]
// ----------------------------------------------------------------------------
// line_column_locator_tb: self-checking bench for the line/column locator
// Streams UTF-8 text and offset queries through the start/busy port, keeps
// its own line start table in step with every accepted item and checks each
// returned line, column, offset and table-full flag in arrival order.
// ----------------------------------------------------------------------------
module line_column_locator_tb;
	import lcl_pkg::*;

	localparam int TABLE_DEPTH  = 4096;
	localparam int OFS_W        = 20;
	localparam int CYCLE_LIMIT  = 200000;
	// margin after the last result; four items may sit in the item queue
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_MAX   = 10;

	// spare request code, the block must ignore it
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// ways a line may end, plus near misses of the separator sequences
	typedef enum int {
		BRK_LF,
		BRK_CR,
		BRK_CRLF,
		BRK_LSEP,
		BRK_PSEP,
		BRK_FALSE_SEQ,
		BRK_LEAD_ONLY
	} line_break_t;

	typedef struct {
		logic [1:0]           req;
		logic [BYTE_W-1:0]    tbyte;
		logic [PAYLOAD_W-1:0] qofs;
	} request_t;

	typedef struct {
		logic [LINE_W-1:0]    line;
		logic [COL_W-1:0]     col;
		logic [PAYLOAD_W-1:0] ofs;
		logic                 full;
	} location_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic [1:0]           req_type     = REQ_CLEAR;
	logic [BYTE_W-1:0]    text_byte    = '0;
	logic [PAYLOAD_W-1:0] query_offset = '0;
	logic                 busy;
	logic                 done;
	logic [LINE_W-1:0]    line_no;
	logic [COL_W-1:0]     column_no;
	logic [PAYLOAD_W-1:0] echo_offset;
	logic                 table_full;

	line_column_locator #(
		.MAX_LINES  (TABLE_DEPTH),
		.OFFSET_BITS(OFS_W)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.text_byte   (text_byte),
		.query_offset(query_offset),
		.done        (done),
		.line_no     (line_no),
		.column_no   (column_no),
		.echo_offset (echo_offset),
		.table_full  (table_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predicted state of the block
	// ------------------------------------------------------------------
	logic [OFS_W-1:0] start_of_line [TABLE_DEPTH];
	int               lines_known      = 1;
	logic [OFS_W-1:0] bytes_seen       = '0;
	logic [BYTE_W-1:0] last_byte       = '0;
	logic [BYTE_W-1:0] byte_before_last = '0;
	logic             dropped_start    = 1'b0;

	request_t  outgoing_requests [$];
	location_t expected_locations [$];

	int  mismatches  = 0;
	int  cycle_count = 0;
	int  items_sent  = 0;
	logic [OFS_W-1:0] text_length = '0;	// bytes queued since the last clear
	logic item_taken = 1'b0;
	int  burst_left  = 0;
	int  gap_left    = 0;
	request_t next_req;

	// back to the empty table: only line 1 at offset 0
	function automatic void forget_text();
		start_of_line[0] = '0;
		lines_known      = 1;
		bytes_seen       = '0;
		last_byte        = '0;
		byte_before_last = '0;
		dropped_start    = 1'b0;
	endfunction

	function automatic void take_text_byte(input logic [BYTE_W-1:0] b);
		logic [OFS_W-1:0] pos;
		logic [OFS_W-1:0] after;
		logic             new_line;
		pos   = bytes_seen;
		after = pos + 1'b1;
		new_line = (b == BYTE_LF) || (b == BYTE_CR) ||
			(byte_before_last == UTF_LEAD && last_byte == UTF_CONT &&
			(b == UTF_LSEP || b == UTF_PSEP));
		if (b == BYTE_LF && last_byte == BYTE_CR) begin
			// cr lf is one terminator: push the start recorded for the cr on by one,
			// but only if that start really belongs to the cr
			if (lines_known > 1 && start_of_line[lines_known-1] == pos)
				start_of_line[lines_known-1] = after;
		end else if (new_line) begin
			if (lines_known < TABLE_DEPTH) begin
				start_of_line[lines_known] = after;
				lines_known++;
			end else begin
				dropped_start = 1'b1;
			end
		end
		byte_before_last = last_byte;
		last_byte        = b;
		bytes_seen       = after;
	endfunction

	// binary search over entries 1 .. lines_known-1 for the first start above
	// the offset, run unchanged on a full table
	function automatic location_t locate_offset(input logic [OFS_W-1:0] q);
		int        first;
		int        n;
		int        half;
		int        mid;
		location_t r;
		first = 1;
		n     = lines_known - 1;
		while (n > 0) begin
			half = n / 2;
			mid  = first + half;
			if (!(q < start_of_line[mid])) begin
				first = mid + 1;
				n     = n - half - 1;
			end else begin
				n = half;
			end
		end
		r.line = first[LINE_W-1:0];
		r.col  = {1'b0, q} - {1'b0, start_of_line[(first - 1) % TABLE_DEPTH]} + 1'b1;
		r.ofs  = q;
		r.full = dropped_start;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic send(input logic [1:0] req, input logic [BYTE_W-1:0] b,
			input logic [PAYLOAD_W-1:0] q);
		request_t r;
		r.req   = req;
		r.tbyte = b;
		r.qofs  = q;
		outgoing_requests.insert(outgoing_requests.size(), r);
		items_sent++;
		if (req == REQ_LOAD)
			text_length = text_length + 1'b1;
		else if (req == REQ_CLEAR)
			text_length = '0;
	endtask

	// unused fields carry noise so the block is seen to ignore them
	task automatic send_text(input logic [BYTE_W-1:0] b);
		send(REQ_LOAD, b, PAYLOAD_W'($urandom));
	endtask

	task automatic send_query(input logic [PAYLOAD_W-1:0] q);
		send(REQ_QUERY, BYTE_W'($urandom), q);
	endtask

	// a query mostly inside the text loaded so far, now and then anywhere
	task automatic send_near_query();
		if ($urandom_range(0, 4) == 0)
			send_query(PAYLOAD_W'($urandom));
		else
			send_query(PAYLOAD_W'($urandom_range(0, int'(text_length) + 2)));
	endtask

	// any byte but a terminator or the lead of a separator sequence
	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do b = BYTE_W'($urandom);
		while (b == BYTE_LF || b == BYTE_CR || b == UTF_LEAD);
		return b;
	endfunction

	task automatic send_break(input line_break_t kind);
		logic [BYTE_W-1:0] tail;
		case (kind)
			BRK_LF: send_text(BYTE_LF);
			BRK_CR: send_text(BYTE_CR);
			BRK_CRLF: begin
				send_text(BYTE_CR);
				send_text(BYTE_LF);
			end
			BRK_LSEP, BRK_PSEP: begin
				send_text(UTF_LEAD);
				send_text(UTF_CONT);
				send_text(kind == BRK_LSEP ? UTF_LSEP : UTF_PSEP);
			end
			BRK_FALSE_SEQ: begin
				// e2 80 followed by anything but a separator tail
				do tail = plain_byte();
				while (tail == UTF_LSEP || tail == UTF_PSEP);
				send_text(UTF_LEAD);
				send_text(UTF_CONT);
				send_text(tail);
			end
			default: begin
				// lead byte alone, or a separator tail with no lead in front
				if ($urandom_range(0, 1)) begin
					send_text(UTF_LEAD);
					send_text(plain_byte());
				end else begin
					send_text(UTF_CONT);
					send_text(UTF_PSEP);
				end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver: items leave the queue at the falling edge, in bursts
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!start || item_taken)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (outgoing_requests.size() > 0) begin
				next_req = outgoing_requests.pop_front();
				req_type     <= next_req.req;
				text_byte    <= next_req.tbyte;
				query_offset <= next_req.qofs;
				start        <= 1'b1;
				if (burst_left > 0) begin
					burst_left = burst_left - 1;
				end else begin
					// mostly short bursts, sometimes a long stretch with no gap at all
					burst_left = ($urandom_range(0, 7) == 0) ?
						$urandom_range(100, 300) : $urandom_range(0, 40);
					gap_left = $urandom_range(0, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// accepted items advance the predicted state at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		item_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			case (req_type)
				REQ_CLEAR: forget_text();
				REQ_LOAD:  take_text_byte(text_byte);
				REQ_QUERY: expected_locations.insert(expected_locations.size(),
					locate_offset(query_offset));
				default: ;	// spare code: no effect, no result
			endcase
		end
	end

	// ------------------------------------------------------------------
	// monitor: every strobed result against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		location_t want;
		if (arst_n && done) begin
			if (expected_locations.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("result with no query waiting: line %0d col %0d ofs 0x%05h full %0b",
						line_no, column_no, echo_offset, table_full);
				mismatches++;
			end else begin
				want = expected_locations.pop_front();
				if (line_no !== want.line || column_no !== want.col ||
						echo_offset !== want.ofs || table_full !== want.full) begin
					if (mismatches < REPORT_MAX)
						$display({"location differs at ofs 0x%05h: expected line %0d col %0d",
							" ofs 0x%05h full %0b, got line %0d col %0d ofs 0x%05h full %0b"},
							want.ofs, want.line, want.col, want.ofs, want.full,
							line_no, column_no, echo_offset, table_full);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		forget_text();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table at both ends of the offset range
		send_query('0);
		send_query('1);
		// each terminator in turn: lf, lone cr, cr lf, both separators
		send_text(8'h61);
		send_text(BYTE_LF);
		send_text(BYTE_CR);
		send_text(BYTE_CR);
		send_text(BYTE_LF);
		send_break(BRK_LSEP);
		send_break(BRK_PSEP);
		// e2 80 with a wrong tail, then the widest byte
		send_text(UTF_LEAD);
		send_text(UTF_CONT);
		send_text(8'h41);
		send_text(8'hff);
		// spare request code carrying a terminator must change nothing
		send(REQ_SPARE, BYTE_LF, '1);
		send_text(BYTE_LF);
		send_query(20'd15);
		send_query(20'd16);
		send_query(20'd3);
		send_query(20'd100);
		// clear in the middle of the text, then query the empty table
		send(REQ_CLEAR, 8'hff, '1);
		send_query(20'd5);
		send_text(8'h00);

		// random text: lines of random content and endings, queries in between
		while (items_sent < 690) begin
			case ($urandom_range(0, 19))
				0: send(REQ_CLEAR, BYTE_W'($urandom), PAYLOAD_W'($urandom));
				1: send(REQ_SPARE, BYTE_W'($urandom), PAYLOAD_W'($urandom));
				2, 3, 4, 5, 6, 7: send_near_query();
				8: send_text(BYTE_W'($urandom));	// raw noise
				default: begin
					repeat ($urandom_range(0, 12)) send_text(plain_byte());
					if ($urandom_range(0, 9) != 0)
						send_break(line_break_t'($urandom_range(BRK_LF, BRK_LEAD_ONLY)));
				end
			endcase
		end

		// closing queries on whatever text is loaded
		repeat (8) send_near_query();
		send_query('0);
		send_query('1);

		// let everything drain
		while (outgoing_requests.size() > 0 || start) @(posedge clk);
		while (expected_locations.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
